// ----- rtl/length_unit_converter_defines.svh -----
// Assertion macros shared by the length unit converter RTL.
`ifndef LENGTH_UNIT_CONVERTER_DEFINES_SVH
`define LENGTH_UNIT_CONVERTER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define LUC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define LUC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/luc_pkg.sv -----
// Shared constants, types and the divider step for the length unit converter.
package luc_pkg;

  localparam int unsigned PIXELS_PER_INCH = 96;
  localparam int unsigned FRACTION_BITS   = 16;

  localparam logic [31:0] ONE_FX      = 32'(64'd1 << FRACTION_BITS);
  localparam logic [31:0] PERCENT_FX  = 32'(64'd100 << FRACTION_BITS);
  localparam logic [31:0] PPI         = 32'(PIXELS_PER_INCH);
  localparam logic [31:0] PX_PER_CM50 = 32'(PIXELS_PER_INCH * 50);
  localparam logic [31:0] PX_PER_MM5  = 32'(PIXELS_PER_INCH * 5);
  localparam logic [31:0] CM_DEN      = 32'd127;
  localparam logic [31:0] PT_PER_IN   = 32'd72;
  localparam logic [31:0] PC_PER_IN   = 32'd6;

  localparam int unsigned QBITS = 32;

  // Unit codes
  localparam logic [3:0] UNIT_UNKNOWN = 4'd0;
  localparam logic [3:0] UNIT_NUMBER  = 4'd1;
  localparam logic [3:0] UNIT_PERCENT = 4'd2;
  localparam logic [3:0] UNIT_EM      = 4'd3;
  localparam logic [3:0] UNIT_EX      = 4'd4;
  localparam logic [3:0] UNIT_PX      = 4'd5;
  localparam logic [3:0] UNIT_CM      = 4'd6;
  localparam logic [3:0] UNIT_MM      = 4'd7;
  localparam logic [3:0] UNIT_IN      = 4'd8;
  localparam logic [3:0] UNIT_PT      = 4'd9;
  localparam logic [3:0] UNIT_PC      = 4'd10;

  // Axis codes
  localparam logic [1:0] AXIS_WIDTH  = 2'd0;
  localparam logic [1:0] AXIS_HEIGHT = 2'd1;
  localparam logic [1:0] AXIS_DIAG   = 2'd2;

  // Direction codes
  localparam logic MODE_TO_USER   = 1'b0;
  localparam logic MODE_FROM_USER = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_VP_OVERRIDE = 3'd0;
  localparam logic [2:0] REG_VP_VALID    = 3'd1;
  localparam logic [2:0] REG_VP_WIDTH    = 3'd2;
  localparam logic [2:0] REG_VP_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_STYLE_VALID = 3'd4;
  localparam logic [2:0] REG_FONT_SIZE   = 3'd5;
  localparam logic [2:0] REG_X_HEIGHT    = 3'd6;

  typedef enum logic [2:0] {
    DG_IDLE,
    DG_SQW,
    DG_SQH,
    DG_HALF,
    DG_ROOT
  } diag_state_t;

  // Decoded request: magnitude times num, divided by den.
  typedef struct packed {
    logic        valid;
    logic        err;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] num;
    logic [31:0] den;
  } op_t;

  // One divider stage.
  typedef struct packed {
    logic        valid;
    logic        err;
    logic        neg;
    logic        ovf;
    logic [31:0] den;
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
  } div_t;

  // Restoring division, one quotient bit.
  function automatic div_t div_step(div_t s);
    div_t        n;
    logic [32:0] r2;
    logic        ge;
    n  = s;
    r2 = {s.rem, s.lo[31]};
    ge = (r2 >= {1'b0, s.den});
    n.rem = ge ? 32'(r2 - {1'b0, s.den}) : r2[31:0];
    n.lo  = {s.lo[30:0], 1'b0};
    n.q   = {s.q[30:0], ge};
    return n;
  endfunction

endpackage

// ----- rtl/luc_decode.sv -----
// Decode stage: picks numerator, denominator and error for one request.
module luc_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              take,
  input  logic [31:0]       length_value,
  input  logic [3:0]        unit,
  input  logic [1:0]        axis,
  input  logic              mode,
  input  logic              vp_override,
  input  logic              vp_valid,
  input  logic [31:0]       vp_width,
  input  logic [31:0]       vp_height,
  input  logic [31:0]       vp_diag,
  input  logic              style_valid,
  input  logic [31:0]       font_size,
  input  logic [15:0]       x_height,
  output luc_pkg::op_t      op
);

  luc_pkg::op_t op_next;
  logic [31:0]  size;

  always_comb begin
    case (axis)
      luc_pkg::AXIS_WIDTH:  size = vp_width;
      luc_pkg::AXIS_HEIGHT: size = vp_height;
      default:              size = vp_diag;
    endcase
  end

  always_comb begin
    op_next.valid = take;
    op_next.neg   = length_value[31];
    op_next.mag   = length_value[31] ? 32'(-length_value) : length_value;
    op_next.num   = 32'd1;
    op_next.den   = 32'd1;
    op_next.err   = 1'b0;
    if (mode == luc_pkg::MODE_TO_USER && vp_override) begin
      op_next.num = size;
      op_next.den = (unit == luc_pkg::UNIT_PERCENT) ? luc_pkg::PERCENT_FX : luc_pkg::ONE_FX;
      op_next.err = !vp_valid;
    end else if (mode == luc_pkg::MODE_TO_USER) begin
      unique case (unit) inside
        luc_pkg::UNIT_NUMBER, luc_pkg::UNIT_PX: ;
        luc_pkg::UNIT_PERCENT: begin
          op_next.num = size;
          op_next.den = luc_pkg::PERCENT_FX;
          op_next.err = !vp_valid;
        end
        luc_pkg::UNIT_EM: begin
          op_next.num = font_size;
          op_next.den = luc_pkg::ONE_FX;
          op_next.err = !style_valid;
        end
        luc_pkg::UNIT_EX: begin
          op_next.num = {16'd0, x_height};
          op_next.err = !style_valid;
        end
        luc_pkg::UNIT_CM: begin
          op_next.num = luc_pkg::PX_PER_CM50;
          op_next.den = luc_pkg::CM_DEN;
        end
        luc_pkg::UNIT_MM: begin
          op_next.num = luc_pkg::PX_PER_MM5;
          op_next.den = luc_pkg::CM_DEN;
        end
        luc_pkg::UNIT_IN: op_next.num = luc_pkg::PPI;
        luc_pkg::UNIT_PT: begin
          op_next.num = luc_pkg::PPI;
          op_next.den = luc_pkg::PT_PER_IN;
        end
        luc_pkg::UNIT_PC: begin
          op_next.num = luc_pkg::PPI;
          op_next.den = luc_pkg::PC_PER_IN;
        end
        default: op_next.err = 1'b1;
      endcase
    end else begin
      unique case (unit) inside
        luc_pkg::UNIT_NUMBER, luc_pkg::UNIT_PX: ;
        luc_pkg::UNIT_PERCENT: begin
          op_next.num = luc_pkg::PERCENT_FX;
          op_next.den = size;
          op_next.err = !vp_valid;
        end
        luc_pkg::UNIT_EM: begin
          op_next.num = luc_pkg::ONE_FX;
          op_next.den = font_size;
          op_next.err = !style_valid;
        end
        luc_pkg::UNIT_EX: begin
          op_next.den = {16'd0, x_height};
          op_next.err = !style_valid;
        end
        luc_pkg::UNIT_CM: begin
          op_next.num = luc_pkg::CM_DEN;
          op_next.den = luc_pkg::PX_PER_CM50;
        end
        luc_pkg::UNIT_MM: begin
          op_next.num = luc_pkg::CM_DEN;
          op_next.den = luc_pkg::PX_PER_MM5;
        end
        luc_pkg::UNIT_IN: op_next.den = luc_pkg::PPI;
        luc_pkg::UNIT_PT: begin
          op_next.num = luc_pkg::PT_PER_IN;
          op_next.den = luc_pkg::PPI;
        end
        luc_pkg::UNIT_PC: begin
          op_next.num = luc_pkg::PC_PER_IN;
          op_next.den = luc_pkg::PPI;
        end
        default: op_next.err = 1'b1;
      endcase
    end
    if (op_next.den == 32'd0) begin
      op_next.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op.valid <= 1'b0;
    end else if (adv) begin
      op <= op_next;
    end
  end

endmodule

// ----- rtl/luc_divider.sv -----
// Multiply, round-bias and 32-stage restoring divider pipeline.
module luc_divider (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  luc_pkg::op_t op,
  output luc_pkg::div_t res
);

  // Multiply stage
  logic        m_valid;
  logic        m_err;
  logic        m_neg;
  logic [31:0] m_den;
  logic [63:0] m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_err  <= op.err;
      m_neg  <= op.neg;
      m_den  <= op.den;
      m_prod <= 64'(op.mag) * 64'(op.num);
    end
  end

  // Bias stage: add half the divisor, detect a quotient of 2^32 or more
  luc_pkg::div_t st [0:luc_pkg::QBITS];
  luc_pkg::div_t pre_next;
  logic [63:0]   biased;

  always_comb begin
    biased          = m_prod + {33'd0, m_den[31:1]};
    pre_next.valid  = m_valid;
    pre_next.err    = m_err;
    pre_next.neg    = m_neg;
    pre_next.den    = m_den;
    pre_next.ovf    = (biased[63:32] >= m_den);
    pre_next.rem    = biased[63:32];
    pre_next.lo     = biased[31:0];
    pre_next.q      = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (adv) begin
      st[0] <= pre_next;
    end
  end

  for (genvar k = 0; k < luc_pkg::QBITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else if (adv) begin
        st[k+1] <= luc_pkg::div_step(st[k]);
      end
    end
  end

  assign res = st[luc_pkg::QBITS];

endmodule

// ----- rtl/luc_diag.sv -----
// Viewport diagonal sequencer: sqrt((w*w + h*h) / 2), one root bit a cycle.
module luc_diag (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] width,
  input  logic [31:0] height,
  output logic [31:0] diag,
  output logic        busy
);

  luc_pkg::diag_state_t state, state_next;

  logic [63:0] w2;
  logic [63:0] prod;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [4:0]  cnt;
  logic [64:0] sum;
  logic [31:0] mul_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= luc_pkg::DG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != luc_pkg::DG_IDLE);
    unique case (state)
      luc_pkg::DG_IDLE: ;
      luc_pkg::DG_SQW:  state_next = luc_pkg::DG_SQH;
      luc_pkg::DG_SQH:  state_next = luc_pkg::DG_HALF;
      luc_pkg::DG_HALF: state_next = luc_pkg::DG_ROOT;
      luc_pkg::DG_ROOT: if (cnt == 5'd31) state_next = luc_pkg::DG_IDLE;
      default:          state_next = luc_pkg::DG_IDLE;
    endcase
    if (start) begin
      state_next = luc_pkg::DG_SQW;
    end
  end

  assign mul_op = (state == luc_pkg::DG_SQW) ? width : height;
  assign sum    = {1'b0, w2} + {1'b0, prod};
  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, diag, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (state == luc_pkg::DG_SQW || state == luc_pkg::DG_SQH) begin
      prod <= 64'(mul_op) * 64'(mul_op);
    end
    if (state == luc_pkg::DG_SQH) begin
      w2 <= prod;
    end
    if (state == luc_pkg::DG_HALF) begin
      rad <= sum[64:1];
      rem <= 34'd0;
      cnt <= 5'd0;
    end else if (state == luc_pkg::DG_ROOT) begin
      rad <= {rad[61:0], 2'b00};
      rem <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      cnt <= cnt + 5'd1;
    end
  end

  // Root register; cleared at reset since the viewport then reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      diag <= 32'd0;
    end else if (state == luc_pkg::DG_HALF) begin
      diag <= 32'd0;
    end else if (state == luc_pkg::DG_ROOT) begin
      diag <= {diag[30:0], ge};
    end
  end

endmodule

// ----- rtl/length_unit_converter.sv -----
// Top level of the length unit converter: config registers, pipeline control, output stage.
//
// Converts a signed Q16.16 length between a CSS-style unit and user pixels.
// The datapath is a fixed pipeline of 36 register stages: decode, a 32x32
// multiply, a round-bias/overflow stage, 32 restoring divider stages (one
// quotient bit each) and the output register. It takes one request per clock
// while in_ready is high; the whole pipeline holds while a finished result
// waits on out_ready. Writing viewport_width or viewport_height starts the
// diagonal unit, which squares both sides on one multiplier and extracts the
// square root one bit a cycle; in_ready is low in the write cycle and while
// the unit is busy. Other register writes take effect at once. in_ready is
// also low during reset. A request with an unsupported unit outside viewport
// override, a missing viewport or style, or a zero divisor returns converted
// 0 with error set; clipped results set saturated.
module length_unit_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] length_value,
  input  logic [3:0]  unit,
  input  logic [1:0]  axis,
  input  logic        mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] converted,
  output logic        error,
  output logic        saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "length_unit_converter_defines.svh"

  // Configuration registers
  logic        vp_override;
  logic        vp_valid;
  logic [31:0] vp_width;
  logic [31:0] vp_height;
  logic        style_valid;
  logic [31:0] font_size;
  logic [15:0] x_height;

  logic          adv;
  logic          diag_busy;
  logic          diag_start;
  logic [31:0]   vp_diag;
  luc_pkg::op_t  op;
  luc_pkg::div_t res;

  logic [31:0] limit;
  logic        sat;
  logic [31:0] clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_override <= 1'b0;
      vp_valid    <= 1'b0;
      vp_width    <= 32'd0;
      vp_height   <= 32'd0;
      style_valid <= 1'b0;
      font_size   <= 32'd1048576;
      x_height    <= 16'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        luc_pkg::REG_VP_OVERRIDE: vp_override <= cfg_data[0];
        luc_pkg::REG_VP_VALID:    vp_valid    <= cfg_data[0];
        luc_pkg::REG_VP_WIDTH:    vp_width    <= cfg_data;
        luc_pkg::REG_VP_HEIGHT:   vp_height   <= cfg_data;
        luc_pkg::REG_STYLE_VALID: style_valid <= cfg_data[0];
        luc_pkg::REG_FONT_SIZE:   font_size   <= cfg_data;
        luc_pkg::REG_X_HEIGHT:    x_height    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Recompute the diagonal whenever a viewport side is written
  assign diag_start = cfg_we && (cfg_index == luc_pkg::REG_VP_WIDTH ||
                                 cfg_index == luc_pkg::REG_VP_HEIGHT);

  luc_diag u_diag (
    .clk    (clk),
    .rst    (rst),
    .start  (diag_start),
    .width  (cfg_index == luc_pkg::REG_VP_WIDTH && cfg_we ? cfg_data : vp_width),
    .height (cfg_index == luc_pkg::REG_VP_HEIGHT && cfg_we ? cfg_data : vp_height),
    .diag   (vp_diag),
    .busy   (diag_busy)
  );

  // Advance every stage unless a finished result is stuck at the output
  assign adv      = !out_valid || out_ready;
  // Hold off requests in reset and while the diagonal is stale or being computed
  assign in_ready = adv && !rst && !diag_busy && !diag_start;

  luc_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .take         (in_valid && in_ready),
    .length_value (length_value),
    .unit         (unit),
    .axis         (axis),
    .mode         (mode),
    .vp_override  (vp_override),
    .vp_valid     (vp_valid),
    .vp_width     (vp_width),
    .vp_height    (vp_height),
    .vp_diag      (vp_diag),
    .style_valid  (style_valid),
    .font_size    (font_size),
    .x_height     (x_height),
    .op           (op)
  );

  luc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .op  (op),
    .res (res)
  );

  // Clip to the signed range: magnitude 2^31 allowed only when negative
  assign limit = res.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat   = res.ovf || (res.q > limit);
  assign clip  = sat ? limit : res.q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      error     <= res.err;
      saturated <= !res.err && sat;
      converted <= res.err ? 32'd0 : (res.neg ? 32'(-clip) : clip);
    end
  end

  `LUC_ASSERT_ALWAYS(a_err_zero, !(out_valid && error) || (converted == 32'd0 && !saturated), "error result must be zero and unsaturated")
  `LUC_ASSERT_ALWAYS(a_sat_pos, !(out_valid && saturated && !converted[31]) || converted == 32'h7FFF_FFFF, "positive saturation must give the maximum")
  `LUC_ASSERT_NEXT(a_diag_block, diag_start, !in_ready, "requests must be held while the diagonal is recomputed")

endmodule

// ----- tb/sv/length_unit_converter_test.sv -----
// Testbench for the length unit converter: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module length_unit_converter_test;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] length_value;
  logic [3:0]  unit;
  logic [1:0]  axis;
  logic        mode;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] converted;
  logic        error;
  logic        saturated;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
    logic        sat;
  } conversion_t;

  // Shadow copy of the configuration registers.
  logic        sh_override;
  logic        sh_vp_valid;
  logic [31:0] sh_width;
  logic [31:0] sh_height;
  logic        sh_style_valid;
  logic [31:0] sh_font_size;
  logic [15:0] sh_x_height;

  conversion_t expected_conversions[$];
  int          mismatch_count;
  // Receiver hold-off; set by the pressure test, counted down by the receiver.
  int          hold_off_cycles;
  // Sender gaps on/off and receiver stalls on/off.
  bit          send_gaps;
  bit          recv_stalls;

  length_unit_converter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .length_value(length_value), .unit(unit), .axis(axis), .mode(mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .converted(converted), .error(error), .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Integer square root, floor, of a 64-bit word.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] probe;
    root = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      probe = root | (64'd1 << b);
      if (probe * probe <= x)
        root = probe;
    end
    return root;
  endfunction

  // Size of the chosen viewport axis; axis three counts as diagonal.
  function automatic logic [63:0] viewport_size(logic [1:0] ax);
    logic [63:0] w2;
    logic [63:0] h2;
    logic [63:0] half;
    if (ax == luc_pkg::AXIS_WIDTH)
      return {32'd0, sh_width};
    if (ax == luc_pkg::AXIS_HEIGHT)
      return {32'd0, sh_height};
    w2   = {32'd0, sh_width} * {32'd0, sh_width};
    h2   = {32'd0, sh_height} * {32'd0, sh_height};
    half = (w2 >> 1) + (h2 >> 1) + (((w2 & 64'd1) + (h2 & 64'd1)) >> 1);
    return floor_sqrt(half);
  endfunction

  // Work out the converted length for one request.
  function automatic conversion_t convert_length(logic [31:0] raw, logic [3:0] u,
                                                 logic [1:0] ax, logic dir);
    conversion_t  r;
    logic         neg;
    logic [63:0]  mag;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [127:0] q;
    logic [63:0]  lim;
    logic         bad;
    neg = raw[31];
    mag = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
    num = 64'd1;
    den = 64'd1;
    bad = 1'b0;
    if (dir == luc_pkg::MODE_TO_USER && sh_override) begin
      num = viewport_size(ax);
      den = (u == luc_pkg::UNIT_PERCENT) ? 64'(luc_pkg::PERCENT_FX)
                                         : 64'(luc_pkg::ONE_FX);
      bad = !sh_vp_valid;
    end else if (dir == luc_pkg::MODE_TO_USER) begin
      case (u)
        luc_pkg::UNIT_NUMBER, luc_pkg::UNIT_PX: ;
        luc_pkg::UNIT_PERCENT: begin
          num = viewport_size(ax);
          den = 64'(luc_pkg::PERCENT_FX);
          bad = !sh_vp_valid;
        end
        luc_pkg::UNIT_EM: begin
          num = 64'(sh_font_size);
          den = 64'(luc_pkg::ONE_FX);
          bad = !sh_style_valid;
        end
        luc_pkg::UNIT_EX: begin
          num = 64'(sh_x_height);
          bad = !sh_style_valid;
        end
        luc_pkg::UNIT_CM: begin
          num = 64'(luc_pkg::PX_PER_CM50);
          den = 64'(luc_pkg::CM_DEN);
        end
        luc_pkg::UNIT_MM: begin
          num = 64'(luc_pkg::PX_PER_MM5);
          den = 64'(luc_pkg::CM_DEN);
        end
        luc_pkg::UNIT_IN: num = 64'(luc_pkg::PPI);
        luc_pkg::UNIT_PT: begin
          num = 64'(luc_pkg::PPI);
          den = 64'(luc_pkg::PT_PER_IN);
        end
        luc_pkg::UNIT_PC: begin
          num = 64'(luc_pkg::PPI);
          den = 64'(luc_pkg::PC_PER_IN);
        end
        default: bad = 1'b1;
      endcase
    end else begin
      case (u)
        luc_pkg::UNIT_NUMBER, luc_pkg::UNIT_PX: ;
        luc_pkg::UNIT_PERCENT: begin
          num = 64'(luc_pkg::PERCENT_FX);
          den = viewport_size(ax);
          bad = !sh_vp_valid;
        end
        luc_pkg::UNIT_EM: begin
          num = 64'(luc_pkg::ONE_FX);
          den = 64'(sh_font_size);
          bad = !sh_style_valid;
        end
        luc_pkg::UNIT_EX: begin
          den = 64'(sh_x_height);
          bad = !sh_style_valid;
        end
        luc_pkg::UNIT_CM: begin
          num = 64'(luc_pkg::CM_DEN);
          den = 64'(luc_pkg::PX_PER_CM50);
        end
        luc_pkg::UNIT_MM: begin
          num = 64'(luc_pkg::CM_DEN);
          den = 64'(luc_pkg::PX_PER_MM5);
        end
        luc_pkg::UNIT_IN: den = 64'(luc_pkg::PPI);
        luc_pkg::UNIT_PT: begin
          num = 64'(luc_pkg::PT_PER_IN);
          den = 64'(luc_pkg::PPI);
        end
        luc_pkg::UNIT_PC: begin
          num = 64'(luc_pkg::PC_PER_IN);
          den = 64'(luc_pkg::PPI);
        end
        default: bad = 1'b1;
      endcase
    end
    if (den == 64'd0)
      bad = 1'b1;
    r = '0;
    if (bad) begin
      r.err = 1'b1;
      return r;
    end
    q   = ({64'd0, mag} * {64'd0, num} + {64'd0, den >> 1}) / {64'd0, den};
    lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 64'd1);
    if (q > {64'd0, lim}) begin
      q = {64'd0, lim};
      r.sat = 1'b1;
    end
    r.value = neg ? 32'((64'd1 << 32) - q[63:0]) : q[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Write one register, mirroring it in the shadow copy; the caller drops cfg_we.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      luc_pkg::REG_VP_OVERRIDE: sh_override    = data[0];
      luc_pkg::REG_VP_VALID:    sh_vp_valid    = data[0];
      luc_pkg::REG_VP_WIDTH:    sh_width       = data;
      luc_pkg::REG_VP_HEIGHT:   sh_height      = data;
      luc_pkg::REG_STYLE_VALID: sh_style_valid = data[0];
      luc_pkg::REG_FONT_SIZE:   sh_font_size   = data;
      luc_pkg::REG_X_HEIGHT:    sh_x_height    = data[15:0];
      default: ;
    endcase
  endtask

  task automatic setup_context(logic ovr, logic vpv, logic [31:0] w, logic [31:0] h,
                               logic stv, logic [31:0] fs, logic [15:0] xh);
    write_reg(luc_pkg::REG_VP_OVERRIDE, {31'd0, ovr});
    write_reg(luc_pkg::REG_VP_VALID, {31'd0, vpv});
    write_reg(luc_pkg::REG_VP_WIDTH, w);
    write_reg(luc_pkg::REG_VP_HEIGHT, h);
    write_reg(luc_pkg::REG_STYLE_VALID, {31'd0, stv});
    write_reg(luc_pkg::REG_FONT_SIZE, fs);
    write_reg(luc_pkg::REG_X_HEIGHT, {16'd0, xh});
    cfg_we <= 1'b0;
  endtask

  // Drop the request line and drain all outstanding results.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_conversions.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // Offer one request, hold it until accepted, then predict its result.
  task automatic send_request(logic [31:0] v, logic [3:0] u, logic [1:0] ax, logic dir);
    int gap;
    gap = send_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    length_value <= v;
    unit         <= u;
    axis         <= ax;
    mode         <= dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_conversions.push_back(convert_length(v, u, ax, dir));
  endtask

  // Receiver: random stalls per result, plus the long hold-off when asked.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
        @(posedge clk);
      end else begin
        stall = recv_stalls ? $urandom_range(0, 11) : 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(out_valid && out_ready)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    conversion_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_conversions.size() == 0) begin
        report_mismatch("unexpected result", converted, 32'd0);
      end else begin
        want = expected_conversions.pop_front();
        if (converted !== want.value)
          report_mismatch("converted", converted, want.value);
        if (error !== want.err)
          report_mismatch("error", {31'd0, error}, {31'd0, want.err});
        if (saturated !== want.sat)
          report_mismatch("saturated", {31'd0, saturated}, {31'd0, want.sat});
      end
    end
  end

  function automatic logic [31:0] random_length();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3) << 16;
      3: return $urandom & 32'h00FF_FFFF;
      4: return -($urandom & 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_size();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 2000) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Every unit and direction, extremes of the length, defaults from reset.
  task automatic test_reset_defaults();
    for (int u = 0; u < 16; u++)
      send_request(32'h0001_8000, 4'(u), 2'(u % 4), 1'(u % 2));
    send_request(32'h8000_0000, luc_pkg::UNIT_PC, luc_pkg::AXIS_WIDTH, luc_pkg::MODE_TO_USER);
    send_request(32'h7FFF_FFFF, luc_pkg::UNIT_IN, luc_pkg::AXIS_WIDTH, luc_pkg::MODE_TO_USER);
    wait_drained();
  endtask

  task automatic test_directed_units();
    logic [31:0] vals[5];
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0064_0000};
    setup_context(1'b0, 1'b1, 32'd800 << 16, 32'd600 << 16, 1'b1, 32'd16 << 16, 16'd9);
    for (int u = 1; u <= 10; u++)
      send_request(vals[u % 5], 4'(u), 2'(u % 4), 1'(u / 6));
    wait_drained();
    // Zero divisors in from-user mode, then a to-user percentage of a zero viewport.
    setup_context(1'b0, 1'b1, 32'd0, 32'd0, 1'b1, 32'd0, 16'd0);
    send_request(32'h0001_0000, luc_pkg::UNIT_PERCENT, luc_pkg::AXIS_HEIGHT,
                 luc_pkg::MODE_FROM_USER);
    send_request(32'h0001_0000, luc_pkg::UNIT_EM, luc_pkg::AXIS_WIDTH,
                 luc_pkg::MODE_FROM_USER);
    send_request(32'h0001_0000, luc_pkg::UNIT_EX, luc_pkg::AXIS_WIDTH,
                 luc_pkg::MODE_FROM_USER);
    send_request(32'h0001_0000, luc_pkg::UNIT_PERCENT, luc_pkg::AXIS_WIDTH,
                 luc_pkg::MODE_TO_USER);
    wait_drained();
    // Viewport override with a missing viewport, then with a full one.
    setup_context(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(32'h0001_0000, luc_pkg::UNIT_UNKNOWN, 2'd3, luc_pkg::MODE_TO_USER);
    wait_drained();
    write_reg(luc_pkg::REG_VP_VALID, 32'd1);
    cfg_we <= 1'b0;
    repeat (40) @(posedge clk);
    send_request(32'h0001_0000, luc_pkg::UNIT_UNKNOWN, 2'd3, luc_pkg::MODE_TO_USER);
    send_request(32'h7FFF_FFFF, luc_pkg::UNIT_PERCENT, luc_pkg::AXIS_DIAG,
                 luc_pkg::MODE_TO_USER);
    send_request(32'h8000_0000, 4'd15, luc_pkg::AXIS_HEIGHT, luc_pkg::MODE_TO_USER);
    send_request(32'h0001_0000, luc_pkg::UNIT_EM, luc_pkg::AXIS_WIDTH,
                 luc_pkg::MODE_FROM_USER);
    wait_drained();
  endtask

  // Random requests over several register settings.
  task automatic test_random(int rounds, int per_round);
    for (int r = 0; r < rounds; r++) begin
      setup_context(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 4) != 0),
                    random_size(), random_size(), 1'($urandom_range(0, 4) != 0),
                    random_size(), 16'($urandom_range(0, 3) == 0 ? 0 : $urandom));
      send_gaps   = (r % 3) != 2;
      recv_stalls = (r % 3) != 1;
      for (int i = 0; i < per_round; i++)
        send_request(random_length(), 4'($urandom_range(0, 15)),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      wait_drained();
    end
  endtask

  // Hold the receiver off so the pipeline fills and stalls the sender.
  task automatic test_back_pressure();
    send_gaps       = 1'b0;
    hold_off_cycles = 120;
    for (int i = 0; i < 60; i++)
      send_request(random_length(), 4'($urandom_range(1, 10)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
    wait_drained();
    send_gaps = 1'b1;
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    length_value    = '0;
    unit            = luc_pkg::UNIT_UNKNOWN;
    axis            = luc_pkg::AXIS_WIDTH;
    mode            = luc_pkg::MODE_TO_USER;
    cfg_we          = 1'b0;
    cfg_index       = luc_pkg::REG_VP_OVERRIDE;
    cfg_data        = '0;
    mismatch_count  = 0;
    hold_off_cycles = 0;
    send_gaps       = 1'b1;
    recv_stalls     = 1'b1;
    sh_override     = 1'b0;
    sh_vp_valid     = 1'b0;
    sh_width        = '0;
    sh_height       = '0;
    sh_style_valid  = 1'b0;
    sh_font_size    = 32'd1048576;
    sh_x_height     = 16'd8;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_units();
    test_back_pressure();
    test_random(10, 60);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/luc_pkg.sv
rtl/luc_decode.sv
rtl/luc_divider.sv
rtl/luc_diag.sv
rtl/length_unit_converter.sv
tb/sv/length_unit_converter_test.sv
